[sv/rtsc_pkg.sv]
`default_nettype none

package rtsc_pkg;

    // Default coordinate width in bits (micrometres and millidegrees).
    localparam int COORD_BITS_DEF = 24;

    // Register widths fixed by the register map.
    localparam int TOL_W  = 23;
    localparam int SAFE_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_CLEARANCE = 2'd2;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_MOVE   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [2:0] PH_NONE      = 3'd0;
    localparam logic [2:0] PH_SURFACE   = 3'd1;
    localparam logic [2:0] PH_DEPARTURE = 3'd2;
    localparam logic [2:0] PH_ROTARY    = 3'd3;
    localparam logic [2:0] PH_APPROACH  = 3'd4;

    localparam logic [1:0] KIND_INITIAL   = 2'd0;
    localparam logic [1:0] KIND_SURFACE   = 2'd1;
    localparam logic [1:0] KIND_CLEARANCE = 2'd2;
    localparam logic [1:0] KIND_CROSS     = 2'd3;

    // Bits of the phase record.
    localparam int SEEN_DEP = 0;
    localparam int SEEN_ROT = 1;
    localparam int SEEN_APP = 2;

    localparam logic [1:0] SURF_MAX = 2'd2;

    typedef struct packed {
        logic still_ok;
        logic verdict_ready;
        logic transfer_safe;
    } result_t;

endpackage

`default_nettype wire

[sv/rotary_transfer_safety_check.sv]
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tuser: opcode; tdata: pose, phase, kind
// m_*       out  m_tvalid / m_tready       tuser: verdict_ready; tdata: still_ok, safe
// cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every item passes an input register and one evaluation stage into the result
// register, and a result is offered once its item has reached the result register.
// One item is taken per cycle while the result is not stalled. The evaluation
// stage reads and updates the check state in the same cycle, with three 23 by 23
// squarers on the finish path and a fourth for the squared tolerance.
// rst_n resets the valid flags, check state and configuration registers, not the
// input and result data; a stalled result holds the result register, and s_tready
// is high while the input register is empty or the result register can advance.
module rotary_transfer_safety_check #(
    parameter int COORD_BITS = rtsc_pkg::COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // From bit 0: pos_x, pos_y, pos_z, angle, phase, transfer_kind, zero fill.
    input  wire logic [((4*COORD_BITS+5+7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire logic [1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // From bit 0: still_ok, transfer_safe, zero fill.
    output logic [7:0] m_tdata,
    // verdict_ready
    output logic [0:0] m_tuser,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [rtsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtsc_pkg::*;

    localparam int CB = COORD_BITS;
    // Common signed width for the coordinate and height compares, with room for the tolerance terms.
    localparam int EW = ((CB > SAFE_W) ? CB : SAFE_W) + 3;
    localparam int SQ_W  = 2 * TOL_W;
    localparam int SUM_W = SQ_W + 2;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [EW-1:0] ext_t;

    function automatic logic [EW-1:0] absd(input ext_t a, input ext_t b);
        ext_t d;
        d = a - b;
        return (d < 0) ? $unsigned(-d) : $unsigned(d);
    endfunction

    // Configuration registers.
    logic [TOL_W-1:0]         tol_reg;
    logic signed [SAFE_W-1:0] safe_h_reg;
    logic [TOL_W-1:0]         zone_cl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= TOL_W'(1);
            safe_h_reg  <= '0;
            zone_cl_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOLERANCE:      tol_reg     <= cfg_data[TOL_W-1:0];
                REG_SAFE_HEIGHT:    safe_h_reg  <= signed'(cfg_data[SAFE_W-1:0]);
                REG_ZONE_CLEARANCE: zone_cl_reg <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    coord_t     in_x_reg, in_y_reg, in_z_reg, in_a_reg;
    logic [2:0] in_ph_reg;
    logic [1:0] in_kind_reg;

    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    logic    fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_x_reg    <= signed'(s_tdata[CB-1:0]);
            in_y_reg    <= signed'(s_tdata[2*CB-1:CB]);
            in_z_reg    <= signed'(s_tdata[3*CB-1:2*CB]);
            in_a_reg    <= signed'(s_tdata[4*CB-1:3*CB]);
            in_ph_reg   <= s_tdata[4*CB+2:4*CB];
            in_kind_reg <= s_tdata[4*CB+4:4*CB+3];
        end
    end

    // Check state.
    coord_t cur_x_reg, cur_y_reg, cur_z_reg, cur_a_reg;
    coord_t start_z_reg, start_a_reg;
    coord_t goal_x_reg, goal_y_reg, goal_z_reg, goal_a_reg;
    coord_t depart_z_reg, rotary_z_reg;
    logic [1:0] kind_reg;
    logic [1:0] surf_cnt_reg;
    logic [2:0] seen_reg;
    logic       any_move_reg;
    logic       failed_reg;

    coord_t cur_x_next, cur_y_next, cur_z_next, cur_a_next;
    coord_t start_z_next, start_a_next;
    coord_t goal_x_next, goal_y_next, goal_z_next, goal_a_next;
    coord_t depart_z_next, rotary_z_next;
    logic [1:0] kind_next;
    logic [1:0] surf_cnt_next;
    logic [2:0] seen_next;
    logic       any_move_next;
    logic       failed_next;
    result_t    out_next;

    // Extended operands.
    ext_t tol_s, safe_lim, zc_s;
    logic [EW-1:0] tol_u;
    logic [2:0] ph;

    assign tol_u    = EW'(tol_reg);
    assign tol_s    = signed'(tol_u);
    assign zc_s     = signed'(EW'(zone_cl_reg));
    assign safe_lim = ext_t'(safe_h_reg) - tol_s;
    assign ph       = (in_ph_reg > PH_APPROACH) ? PH_NONE : in_ph_reg;

    // Arrival: an axis beyond tolerance fails outright, so the squarers only
    // ever see differences that fit the tolerance width.
    logic [EW-1:0]    dx, dy, dz;
    logic [SQ_W-1:0]  sq_x, sq_y, sq_z, tol_sq;
    logic [SUM_W-1:0] sq_sum;
    logic             arrived;

    assign dx     = absd(ext_t'(cur_x_reg), ext_t'(goal_x_reg));
    assign dy     = absd(ext_t'(cur_y_reg), ext_t'(goal_y_reg));
    assign dz     = absd(ext_t'(cur_z_reg), ext_t'(goal_z_reg));
    assign sq_x   = dx[TOL_W-1:0] * dx[TOL_W-1:0];
    assign sq_y   = dy[TOL_W-1:0] * dy[TOL_W-1:0];
    assign sq_z   = dz[TOL_W-1:0] * dz[TOL_W-1:0];
    assign tol_sq = tol_reg * tol_reg;
    assign sq_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    assign arrived = (dx <= tol_u) && (dy <= tol_u) && (dz <= tol_u)
                  && (sq_sum <= SUM_W'(tol_sq))
                  && (absd(ext_t'(cur_a_reg), ext_t'(goal_a_reg)) <= tol_u);

    logic verdict;
    logic a_home;

    assign a_home = absd(ext_t'(cur_a_reg), ext_t'(start_a_reg)) <= tol_u;

    always_comb
    begin
        case (kind_reg)
            KIND_SURFACE:
                verdict = (surf_cnt_reg <= 2'd1) && (seen_reg == '0) && a_home;
            KIND_CLEARANCE:
                verdict = !seen_reg[SEEN_ROT] && seen_reg[SEEN_APP]
                       && (ext_t'(depart_z_reg) >= ext_t'(start_z_reg) + zc_s - tol_s)
                       && (ext_t'(rotary_z_reg) >= ext_t'(goal_z_reg) + zc_s - tol_s)
                       && a_home;
            default:
                verdict = seen_reg[SEEN_APP] && any_move_reg
                       && ((absd(ext_t'(goal_a_reg), ext_t'(start_a_reg)) <= tol_u)
                           || seen_reg[SEEN_ROT])
                       && (seen_reg[SEEN_DEP] || (ext_t'(start_z_reg) >= safe_lim));
        endcase
    end

    logic a_changes;
    logic rot_low;

    assign a_changes = absd(ext_t'(in_a_reg), ext_t'(cur_a_reg)) > tol_u;
    // Rotation needs both ends of the move at or above the safe height less the tolerance.
    assign rot_low   = (ext_t'(cur_z_reg) < safe_lim) || (ext_t'(in_z_reg) < safe_lim);

    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_z_next    = cur_z_reg;
        cur_a_next    = cur_a_reg;
        start_z_next  = start_z_reg;
        start_a_next  = start_a_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        goal_z_next   = goal_z_reg;
        goal_a_next   = goal_a_reg;
        depart_z_next = depart_z_reg;
        rotary_z_next = rotary_z_reg;
        kind_next     = kind_reg;
        surf_cnt_next = surf_cnt_reg;
        seen_next     = seen_reg;
        any_move_next = any_move_reg;
        failed_next   = failed_reg;
        out_next.verdict_ready = 1'b0;
        out_next.transfer_safe = 1'b0;

        case (in_op_reg)
            OP_START:
            begin
                cur_x_next    = in_x_reg;
                cur_y_next    = in_y_reg;
                cur_z_next    = in_z_reg;
                cur_a_next    = in_a_reg;
                start_z_next  = in_z_reg;
                start_a_next  = in_a_reg;
                kind_next     = in_kind_reg;
                surf_cnt_next = '0;
                seen_next     = '0;
                any_move_next = 1'b0;
                failed_next   = 1'b0;
                depart_z_next = '0;
                rotary_z_next = '0;
            end
            OP_TARGET:
            begin
                goal_x_next = in_x_reg;
                goal_y_next = in_y_reg;
                goal_z_next = in_z_reg;
                goal_a_next = in_a_reg;
            end
            OP_MOVE:
            begin
                if (in_kind_reg != kind_reg)
                begin
                    failed_next = 1'b1;
                end
                if (ph == PH_SURFACE && surf_cnt_reg < SURF_MAX)
                begin
                    surf_cnt_next = surf_cnt_reg + 2'd1;
                end
                if (ph == PH_DEPARTURE)
                begin
                    seen_next[SEEN_DEP] = 1'b1;
                    depart_z_next       = in_z_reg;
                end
                if (ph == PH_ROTARY)
                begin
                    seen_next[SEEN_ROT] = 1'b1;
                    rotary_z_next       = in_z_reg;
                end
                if (ph == PH_APPROACH)
                begin
                    seen_next[SEEN_APP] = 1'b1;
                    if (absd(ext_t'(cur_a_reg), ext_t'(goal_a_reg)) > tol_u)
                    begin
                        failed_next = 1'b1;
                    end
                end
                if (a_changes && (ph != PH_ROTARY || rot_low))
                begin
                    failed_next = 1'b1;
                end
                any_move_next = 1'b1;
                cur_x_next    = in_x_reg;
                cur_y_next    = in_y_reg;
                cur_z_next    = in_z_reg;
                cur_a_next    = in_a_reg;
            end
            default:
            begin
                out_next.verdict_ready = 1'b1;
                out_next.transfer_safe = !failed_reg && arrived && verdict;
            end
        endcase

        out_next.still_ok = !failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_z_reg     <= '0;
            cur_a_reg     <= '0;
            start_z_reg   <= '0;
            start_a_reg   <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_z_reg    <= '0;
            goal_a_reg    <= '0;
            depart_z_reg  <= '0;
            rotary_z_reg  <= '0;
            kind_reg      <= '0;
            surf_cnt_reg  <= '0;
            seen_reg      <= '0;
            any_move_reg  <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (fire)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_z_reg     <= cur_z_next;
            cur_a_reg     <= cur_a_next;
            start_z_reg   <= start_z_next;
            start_a_reg   <= start_a_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            goal_z_reg    <= goal_z_next;
            goal_a_reg    <= goal_a_next;
            depart_z_reg  <= depart_z_next;
            rotary_z_reg  <= rotary_z_next;
            kind_reg      <= kind_next;
            surf_cnt_reg  <= surf_cnt_next;
            seen_reg      <= seen_next;
            any_move_reg  <= any_move_next;
            failed_reg    <= failed_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'd0, out_reg.transfer_safe, out_reg.still_ok};
    assign m_tuser[0] = out_reg.verdict_ready;

`ifndef NO_ASSERTIONS
    // A safe verdict can only come with a clean record.
    a_safe_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tuser[0])
        else $error("safe verdict on a failed or non-finish result");

    // A failure is raised only by a move item.
    a_fail_from_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(failed_reg) && failed_reg |-> $past(fire) && $past(in_op_reg) == OP_MOVE)
        else $error("failure raised outside a move");

    // A failure is cleared only by a start item.
    a_clear_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $past(failed_reg) && !failed_reg |-> $past(fire) && $past(in_op_reg) == OP_START)
        else $error("failure cleared outside a start");

    // The surface counter saturates at two.
    a_surf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        surf_cnt_reg <= SURF_MAX)
        else $error("surface count beyond saturation");

    // Finish items leave the check state untouched.
    a_finish_stable: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_op_reg == OP_FINISH |=> $stable(failed_reg) && $stable(seen_reg)
                                          && $stable(cur_a_reg))
        else $error("finish item changed the state");
`endif

endmodule

`default_nettype wire
